/* sv/msac_pkg.sv */
package msac_pkg;

   // verdict codes
   typedef enum logic [1:0] {
      VERDICT_ALLOW = 2'd0,
      VERDICT_DENY  = 2'd1,
      VERDICT_VOID  = 2'd2
   } verdict_type;

   // request word as carried on req_tdata, lowest field last
   typedef struct packed {
      logic [1:0]  pad;
      logic        tool_access;
      logic [1:0]  security_level;
      logic [15:0] index_object_type;
      logic [7:0]  byte_5;
      logic [7:0]  byte_4;
      logic [7:0]  byte_3;
      logic [7:0]  byte_2;
      logic [7:0]  byte_1;
      logic [7:0]  byte_0;
      logic [2:0]  frame_length;
   } req_word_type;

   localparam int unsigned REQ_DATA_W = $bits(req_word_type);

   // service codes
   localparam logic [9:0] SVC_PROP_WRITE      = 10'h3D7;
   localparam logic [9:0] SVC_FUNC_COMMAND    = 10'h2C7;
   localparam logic [9:0] SVC_PROP_READ       = 10'h3D5;
   localparam logic [9:0] SVC_FUNC_STATE_READ = 10'h2C8;
   localparam logic [9:0] SVC_EXT_WRITE_CON   = 10'h1CE;
   localparam logic [9:0] SVC_EXT_WRITE_UCON  = 10'h1D0;
   localparam logic [9:0] SVC_EXT_FUNC_CMD    = 10'h1D4;
   localparam logic [9:0] SVC_EXT_READ        = 10'h1CC;
   localparam logic [9:0] SVC_EXT_FUNC_STATE  = 10'h1D5;
   localparam logic [9:0] SVC_DESC_READ       = 10'h3D8;
   localparam logic [9:0] SVC_EXT_DESC_READ   = 10'h1D2;
   localparam logic [9:0] SVC_DEVDESC_READ    = 10'h300;
   localparam logic [9:0] SVC_MEM_READ        = 10'h200;
   localparam logic [9:0] SVC_EXT_MEM_READ    = 10'h1FD;
   localparam logic [9:0] SVC_USER_MEM_READ   = 10'h2C0;
   localparam logic [9:0] SVC_USER_MFR_READ   = 10'h2C5;
   localparam logic [9:0] SVC_MEM_WRITE       = 10'h280;
   localparam logic [9:0] SVC_EXT_MEM_WRITE   = 10'h1FB;
   localparam logic [9:0] SVC_USER_MEM_WRITE  = 10'h2C2;
   localparam logic [9:0] SVC_MEM_BIT_WRITE   = 10'h3CA;
   localparam logic [9:0] SVC_ADC_READ        = 10'h3C3;
   localparam logic [9:0] SVC_RESTART         = 10'h380;
   localparam logic [9:0] SVC_RESTART_MASTER  = 10'h381;
   localparam logic [9:0] SVC_ADDR_WRITE      = 10'h0C0;
   localparam logic [9:0] SVC_DOMAIN_WRITE    = 10'h3DE;
   localparam logic [9:0] SVC_DOMAIN_SEL      = 10'h3E0;
   localparam logic [9:0] SVC_ADC_CTRL        = 10'h180;
   localparam logic [9:0] SVC_KEY_WRITE       = 10'h3D3;
   localparam logic [9:0] SVC_AUTH_REQ        = 10'h3C0;
   localparam logic [9:0] SVC_AUTH_RSP        = 10'h3C1;

   // policy words: off half in [19:10], on half in [9:0]
   localparam logic [19:0] POL_STD       = {10'h3FF, 10'h0CC};
   localparam logic [19:0] POL_OPEN      = {10'h3FF, 10'h1FF};
   localparam logic [19:0] POL_TOOL      = {10'h3FF, 10'h00C};
   localparam logic [19:0] POL_TOOL_ALL  = {10'h00C, 10'h00C};
   localparam logic [19:0] POL_AUTH      = {10'h15F, 10'h04C};
   localparam logic [19:0] POL_CONF_TOOL = {10'h008, 10'h008};
   localparam logic [19:0] POL_SEC_STD   = {10'h1FF, 10'h0CC};
   localparam logic [19:0] POL_NONE      = {10'h3FF, 10'h000};

   localparam logic [15:0] OBJ_NONE = 16'hFFFF;
   localparam logic [15:0] OBJ_SEC  = 16'd17;

   function automatic logic [19:0] lookup_pol(input logic [15:0] obj, input logic [11:0] pid);
      logic [19:0] pol;
      unique case ({obj, pid})
         {16'd0, 12'd56}:  pol = POL_OPEN;
         {16'd0, 12'd57}, {16'd0, 12'd58}, {16'd0, 12'd59},
         {16'd0, 12'd70}, {16'd0, 12'd82}: pol = POL_TOOL;
         {16'd6, 12'd51}, {16'd6, 12'd58}: pol = POL_OPEN;
         {16'd6, 12'd80}, {16'd6, 12'd81}, {16'd6, 12'd82},
         {16'd6, 12'd83}: pol = POL_TOOL_ALL;
         {16'd8, 12'd51}, {16'd8, 12'd52}, {16'd8, 12'd53},
         {16'd8, 12'd57}, {16'd8, 12'd58}, {16'd8, 12'd68}: pol = POL_OPEN;
         {16'd11, 12'd79}, {16'd11, 12'd94}, {16'd11, 12'd95},
         {16'd11, 12'd96}, {16'd11, 12'd97}: pol = POL_AUTH;
         {16'd11, 12'd91}, {16'd11, 12'd92}, {16'd11, 12'd93}: pol = POL_CONF_TOOL;
         {16'd17, 12'd5}, {16'd17, 12'd51}, {16'd17, 12'd62}: pol = POL_AUTH;
         {16'd17, 12'd52}, {16'd17, 12'd53}, {16'd17, 12'd54},
         {16'd17, 12'd58}, {16'd17, 12'd59}, {16'd17, 12'd60},
         {16'd17, 12'd61}: pol = POL_TOOL_ALL;
         {16'd17, 12'd55}, {16'd17, 12'd57}: pol = POL_SEC_STD;
         {16'd17, 12'd56}: pol = POL_CONF_TOOL;
         default: begin
            if (obj == OBJ_SEC && pid > 12'd2) begin
               pol = POL_TOOL_ALL;
            end else begin
               pol = POL_STD;
            end
         end
      endcase
      return pol;
   endfunction

   // bit 0 read, bit 1 write
   function automatic logic [1:0] right_bits(input logic [19:0] pol, input logic secure,
                                             input logic [1:0] sec, input logic tool);
      logic [9:0] half;
      logic [1:0] rb;
      half = secure ? pol[9:0] : pol[19:10];
      priority if (sec == 2'd0) begin
         rb = half[9:8];
      end else if (tool) begin
         rb = sec[1] ? half[3:2] : half[1:0];
      end else begin
         rb = sec[1] ? half[7:6] : half[5:4];
      end
      return rb;
   endfunction

   function automatic logic [19:0] restart_pol(input logic [5:0] rtype, input logic [7:0] erase);
      logic [19:0] pol;
      if (rtype == 6'd0) begin
         pol = POL_STD;
      end else begin
         unique case (erase)
            8'h01: pol = POL_STD;
            8'h02, 8'h05, 8'h06, 8'h07: pol = POL_TOOL;
            default: pol = POL_NONE;
         endcase
      end
      return pol;
   endfunction

endpackage

/* sv/management_service_access_check.sv */
// Management access check: one request word in, one verdict word out. Takes a
// word every cycle unless a low rsp_tready holds the pipe; each verdict passes
// through the input register, then the result register, and waits there while
// rsp_tready is low. secure_mode selects the on half of every policy and must
// only be written with no request in flight.
module management_service_access_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // frame_length[2:0], byte_0..byte_5[50:3], index_object_type[66:51],
   // security_level[68:67], tool_access[69], zero[71:70]
   input  logic [71:0] req_tdata,
   // apdu_type[9:0]
   input  logic [9:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // verdict[1:0], zero[7:2]
   output logic [7:0]  rsp_tdata,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic                  secure_mode_ff;
   logic                  s1_valid_ff, s1_valid_in;
   msac_pkg::req_word_type s1_word_ff;
   logic [9:0]            s1_apdu_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   msac_pkg::verdict_type rsp_verdict_ff, verdict;
   logic                  s1_adv;

   assign s1_adv      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_adv;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         secure_mode_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            secure_mode_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_word_ff <= msac_pkg::req_word_type'(req_tdata);
         s1_apdu_ff <= req_tuser;
      end
      if (s1_adv) begin
         rsp_verdict_ff <= verdict;
      end
   end

   // decode
   logic [15:0] ext_obj;
   logic [11:0] ext_pid;
   logic [2:0]  len;
   logic [5:0]  rst_type;
   logic [7:0]  rst_erase;
   logic [1:0]  rb_idx, rb_ext, rb_std, rb_tool, rb_rst;
   logic        iot_none;

   always_comb begin
      len       = s1_word_ff.frame_length;
      ext_obj   = {s1_word_ff.byte_1, s1_word_ff.byte_2};
      ext_pid   = {s1_word_ff.byte_4[3:0], s1_word_ff.byte_5};
      iot_none  = s1_word_ff.index_object_type == msac_pkg::OBJ_NONE;
      rst_type  = (len >= 3'd1) ? s1_word_ff.byte_0[5:0] : 6'd0;
      rst_erase = (rst_type == 6'd1 && len >= 3'd2) ? s1_word_ff.byte_1 : 8'd0;

      rb_idx  = msac_pkg::right_bits(
                   msac_pkg::lookup_pol(s1_word_ff.index_object_type,
                                        {4'd0, s1_word_ff.byte_2}),
                   secure_mode_ff, s1_word_ff.security_level, s1_word_ff.tool_access);
      rb_ext  = msac_pkg::right_bits(msac_pkg::lookup_pol(ext_obj, ext_pid),
                   secure_mode_ff, s1_word_ff.security_level, s1_word_ff.tool_access);
      rb_std  = msac_pkg::right_bits(msac_pkg::POL_STD,
                   secure_mode_ff, s1_word_ff.security_level, s1_word_ff.tool_access);
      rb_tool = msac_pkg::right_bits(msac_pkg::POL_TOOL,
                   secure_mode_ff, s1_word_ff.security_level, s1_word_ff.tool_access);
      rb_rst  = msac_pkg::right_bits(msac_pkg::restart_pol(rst_type, rst_erase),
                   secure_mode_ff, s1_word_ff.security_level, s1_word_ff.tool_access);

      unique case (s1_apdu_ff)
         msac_pkg::SVC_PROP_WRITE, msac_pkg::SVC_FUNC_COMMAND: begin
            if (len < 3'd3) verdict = msac_pkg::VERDICT_DENY;
            else if (iot_none) verdict = msac_pkg::VERDICT_ALLOW;
            else verdict = rb_idx[1] ? msac_pkg::VERDICT_ALLOW : msac_pkg::VERDICT_DENY;
         end
         msac_pkg::SVC_PROP_READ, msac_pkg::SVC_FUNC_STATE_READ: begin
            if (len < 3'd3) verdict = msac_pkg::VERDICT_DENY;
            else if (iot_none) verdict = msac_pkg::VERDICT_ALLOW;
            else verdict = rb_idx[0] ? msac_pkg::VERDICT_ALLOW : msac_pkg::VERDICT_DENY;
         end
         msac_pkg::SVC_EXT_WRITE_CON, msac_pkg::SVC_EXT_WRITE_UCON,
         msac_pkg::SVC_EXT_FUNC_CMD: begin
            if (len < 3'd6) verdict = msac_pkg::VERDICT_DENY;
            else verdict = rb_ext[1] ? msac_pkg::VERDICT_ALLOW : msac_pkg::VERDICT_DENY;
         end
         msac_pkg::SVC_EXT_READ, msac_pkg::SVC_EXT_FUNC_STATE: begin
            if (len < 3'd6) verdict = msac_pkg::VERDICT_DENY;
            else verdict = rb_ext[0] ? msac_pkg::VERDICT_ALLOW : msac_pkg::VERDICT_DENY;
         end
         msac_pkg::SVC_DESC_READ: begin
            if (len < 3'd4 || s1_word_ff.byte_2 == 8'd0 || iot_none) begin
               verdict = msac_pkg::VERDICT_ALLOW;
            end else begin
               verdict = (rb_idx != 2'd0) ? msac_pkg::VERDICT_ALLOW : msac_pkg::VERDICT_DENY;
            end
         end
         msac_pkg::SVC_EXT_DESC_READ: begin
            if (len < 3'd6) verdict = msac_pkg::VERDICT_DENY;
            else if (ext_pid == 12'd0) verdict = msac_pkg::VERDICT_ALLOW;
            else verdict = (rb_ext != 2'd0) ? msac_pkg::VERDICT_ALLOW : msac_pkg::VERDICT_DENY;
         end
         msac_pkg::SVC_DEVDESC_READ:
            verdict = (rb_std != 2'd0) ? msac_pkg::VERDICT_ALLOW : msac_pkg::VERDICT_VOID;
         msac_pkg::SVC_MEM_READ, msac_pkg::SVC_EXT_MEM_READ, msac_pkg::SVC_USER_MEM_READ,
         msac_pkg::SVC_USER_MFR_READ:
            verdict = rb_std[0] ? msac_pkg::VERDICT_ALLOW : msac_pkg::VERDICT_DENY;
         msac_pkg::SVC_MEM_WRITE, msac_pkg::SVC_EXT_MEM_WRITE, msac_pkg::SVC_USER_MEM_WRITE,
         msac_pkg::SVC_MEM_BIT_WRITE, msac_pkg::SVC_ADC_READ:
            verdict = rb_std[1] ? msac_pkg::VERDICT_ALLOW : msac_pkg::VERDICT_DENY;
         msac_pkg::SVC_RESTART, msac_pkg::SVC_RESTART_MASTER:
            verdict = (rb_rst != 2'd0) ? msac_pkg::VERDICT_ALLOW : msac_pkg::VERDICT_DENY;
         msac_pkg::SVC_ADDR_WRITE, msac_pkg::SVC_DOMAIN_WRITE, msac_pkg::SVC_DOMAIN_SEL,
         msac_pkg::SVC_ADC_CTRL:
            verdict = (rb_tool != 2'd0) ? msac_pkg::VERDICT_ALLOW : msac_pkg::VERDICT_DENY;
         msac_pkg::SVC_KEY_WRITE, msac_pkg::SVC_AUTH_REQ, msac_pkg::SVC_AUTH_RSP:
            verdict = (rb_std != 2'd0) ? msac_pkg::VERDICT_ALLOW : msac_pkg::VERDICT_DENY;
         default:
            verdict = msac_pkg::VERDICT_ALLOW;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_verdict_ff};

endmodule

/* sv/msac_checker.sv */
module msac_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // a held verdict word may not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == msac_pkg::VERDICT_ALLOW ||
                      rsp_tdata[1:0] == msac_pkg::VERDICT_DENY ||
                      rsp_tdata[1:0] == msac_pkg::VERDICT_VOID))
      else $error("bad verdict code");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:2] == 6'd0)
      else $error("rsp pad bits set");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind management_service_access_check msac_checker u_msac_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* sim/tb.sv */
module tb;

   // policy words as {off half, on half}
   localparam logic [19:0] PW_STD      = {10'h3FF, 10'h0CC};
   localparam logic [19:0] PW_OPEN     = {10'h3FF, 10'h1FF};
   localparam logic [19:0] PW_TOOL     = {10'h3FF, 10'h00C};
   localparam logic [19:0] PW_TOOL_ALL = {10'h00C, 10'h00C};
   localparam logic [19:0] PW_AUTH     = {10'h15F, 10'h04C};
   localparam logic [19:0] PW_CONF     = {10'h008, 10'h008};
   localparam logic [19:0] PW_SEC_STD  = {10'h1FF, 10'h0CC};
   localparam logic [19:0] PW_NONE     = {10'h3FF, 10'h000};

   // service codes that no check claims
   localparam logic [9:0] SVC_UNLISTED_TOP = 10'h3FF;
   localparam logic [9:0] SVC_UNLISTED_LOW = 10'h000;

   // expected column of the directed rows; bit 2 set means ask the predictor
   localparam logic [2:0] W_ALLOW = {1'b0, msac_pkg::VERDICT_ALLOW};
   localparam logic [2:0] W_DENY  = {1'b0, msac_pkg::VERDICT_DENY};
   localparam logic [2:0] W_VOID  = {1'b0, msac_pkg::VERDICT_VOID};
   localparam logic [2:0] W_PRED  = 3'b100;

   localparam logic [9:0] SERVICES [30] = '{
      msac_pkg::SVC_PROP_WRITE, msac_pkg::SVC_FUNC_COMMAND, msac_pkg::SVC_PROP_READ,
      msac_pkg::SVC_FUNC_STATE_READ, msac_pkg::SVC_EXT_WRITE_CON,
      msac_pkg::SVC_EXT_WRITE_UCON, msac_pkg::SVC_EXT_FUNC_CMD, msac_pkg::SVC_EXT_READ,
      msac_pkg::SVC_EXT_FUNC_STATE, msac_pkg::SVC_DESC_READ, msac_pkg::SVC_EXT_DESC_READ,
      msac_pkg::SVC_DEVDESC_READ, msac_pkg::SVC_MEM_READ, msac_pkg::SVC_EXT_MEM_READ,
      msac_pkg::SVC_USER_MEM_READ, msac_pkg::SVC_USER_MFR_READ, msac_pkg::SVC_MEM_WRITE,
      msac_pkg::SVC_EXT_MEM_WRITE, msac_pkg::SVC_USER_MEM_WRITE,
      msac_pkg::SVC_MEM_BIT_WRITE, msac_pkg::SVC_ADC_READ, msac_pkg::SVC_RESTART,
      msac_pkg::SVC_RESTART_MASTER, msac_pkg::SVC_ADDR_WRITE, msac_pkg::SVC_DOMAIN_WRITE,
      msac_pkg::SVC_DOMAIN_SEL, msac_pkg::SVC_ADC_CTRL, msac_pkg::SVC_KEY_WRITE,
      msac_pkg::SVC_AUTH_REQ, msac_pkg::SVC_AUTH_RSP};
   localparam logic [15:0] OBJECTS [6] = '{16'd0, 16'd6, 16'd8, 16'd11, msac_pkg::OBJ_SEC,
                                           msac_pkg::OBJ_NONE};
   localparam logic [11:0] PIDS [32] = '{
      12'd0, 12'd1, 12'd2, 12'd3, 12'd5, 12'd51, 12'd52, 12'd53, 12'd54, 12'd55,
      12'd56, 12'd57, 12'd58, 12'd59, 12'd60, 12'd61, 12'd62, 12'd68, 12'd70, 12'd79,
      12'd80, 12'd81, 12'd82, 12'd83, 12'd91, 12'd92, 12'd93, 12'd94, 12'd95, 12'd96,
      12'd97, 12'd200};
   localparam logic [7:0] ERASE_CODES [8] = '{8'h00, 8'h01, 8'h02, 8'h05, 8'h06, 8'h07,
                                             8'h03, 8'hFF};

   typedef enum logic [2:0] {
      CHK_FIXED, CHK_READ, CHK_WRITE, CHK_SERVICE, CHK_DEVDESC
   } check_kind_type;

   typedef struct packed {
      logic                   sm;
      logic [9:0]             svc;
      msac_pkg::req_word_type w;
      logic [2:0]             want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [9:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_wr_en;
   logic        csr_wr_data;

   logic        secure_now = 1'b0;
   bit          steady = 1'b0;
   int          mismatches = 0;
   msac_pkg::verdict_type pending_verdicts[$];
   stim_row_type stim_rows[$];

   management_service_access_check DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [19:0] policy_of(input logic [15:0] obj, input logic [11:0] pid);
      logic [19:0] p;
      p = (obj == msac_pkg::OBJ_SEC && pid > 12'd2) ? PW_TOOL_ALL : PW_STD;
      case (obj)
         16'd0: case (pid)
            12'd56: p = PW_OPEN;
            12'd57, 12'd58, 12'd59, 12'd70, 12'd82: p = PW_TOOL;
            default: ;
         endcase
         16'd6: case (pid)
            12'd51, 12'd58: p = PW_OPEN;
            12'd80, 12'd81, 12'd82, 12'd83: p = PW_TOOL_ALL;
            default: ;
         endcase
         16'd8: case (pid)
            12'd51, 12'd52, 12'd53, 12'd57, 12'd58, 12'd68: p = PW_OPEN;
            default: ;
         endcase
         16'd11: case (pid)
            12'd79, 12'd94, 12'd95, 12'd96, 12'd97: p = PW_AUTH;
            12'd91, 12'd92, 12'd93: p = PW_CONF;
            default: ;
         endcase
         16'd17: case (pid)
            12'd5, 12'd51, 12'd62: p = PW_AUTH;
            12'd52, 12'd53, 12'd54, 12'd58, 12'd59, 12'd60, 12'd61: p = PW_TOOL_ALL;
            12'd55, 12'd57: p = PW_SEC_STD;
            12'd56: p = PW_CONF;
            default: ;
         endcase
         default: ;
      endcase
      return p;
   endfunction

   // pair offset in a half: 8 with no security, 4 runtime key, 0 tool key,
   // plus 2 for confidential (level 3 counts as confidential)
   function automatic logic [1:0] right_pair(input logic [19:0] pol, input logic sm,
                                             input logic [1:0] sec, input logic tool);
      logic [4:0]  sh;
      logic [19:0] shifted;
      sh = sm ? 5'd0 : 5'd10;
      if (sec == 2'd0) begin
         sh = sh + 5'd8;
      end else begin
         sh = sh + (tool ? 5'd0 : 5'd4) + (sec[1] ? 5'd2 : 5'd0);
      end
      shifted = pol >> sh;
      return shifted[1:0];
   endfunction

   function automatic msac_pkg::verdict_type access_verdict(input logic [9:0] svc,
                                                            input msac_pkg::req_word_type w,
                                                            input logic sm);
      logic [19:0] pol;
      logic [15:0] ext_obj;
      logic [11:0] ext_pid;
      logic [5:0]  rtype;
      logic [7:0]  erase;
      logic [1:0]  rights;
      logic        wr;
      check_kind_type kind;
      msac_pkg::verdict_type v;
      ext_obj = {w.byte_1, w.byte_2};
      ext_pid = {w.byte_4[3:0], w.byte_5};
      wr = 1'b0;
      pol = PW_STD;
      kind = CHK_FIXED;
      v = msac_pkg::VERDICT_ALLOW;
      case (svc)
         msac_pkg::SVC_PROP_WRITE, msac_pkg::SVC_FUNC_COMMAND, msac_pkg::SVC_PROP_READ,
         msac_pkg::SVC_FUNC_STATE_READ: begin
            wr = (svc == msac_pkg::SVC_PROP_WRITE) || (svc == msac_pkg::SVC_FUNC_COMMAND);
            if (w.frame_length < 3'd3) begin
               v = msac_pkg::VERDICT_DENY;
            end else if (w.index_object_type != msac_pkg::OBJ_NONE) begin
               pol = policy_of(w.index_object_type, {4'h0, w.byte_2});
               kind = wr ? CHK_WRITE : CHK_READ;
            end
         end
         msac_pkg::SVC_EXT_WRITE_CON, msac_pkg::SVC_EXT_WRITE_UCON, msac_pkg::SVC_EXT_FUNC_CMD,
         msac_pkg::SVC_EXT_READ, msac_pkg::SVC_EXT_FUNC_STATE: begin
            wr = (svc == msac_pkg::SVC_EXT_WRITE_CON) || (svc == msac_pkg::SVC_EXT_WRITE_UCON) ||
                 (svc == msac_pkg::SVC_EXT_FUNC_CMD);
            if (w.frame_length < 3'd6) begin
               v = msac_pkg::VERDICT_DENY;
            end else begin
               pol = policy_of(ext_obj, ext_pid);
               kind = wr ? CHK_WRITE : CHK_READ;
            end
         end
         msac_pkg::SVC_DESC_READ: begin
            if (w.frame_length >= 3'd4 && w.byte_2 != 8'd0 &&
                w.index_object_type != msac_pkg::OBJ_NONE) begin
               pol = policy_of(w.index_object_type, {4'h0, w.byte_2});
               kind = CHK_SERVICE;
            end
         end
         msac_pkg::SVC_EXT_DESC_READ: begin
            if (w.frame_length < 3'd6) begin
               v = msac_pkg::VERDICT_DENY;
            end else if (ext_pid != 12'd0) begin
               pol = policy_of(ext_obj, ext_pid);
               kind = CHK_SERVICE;
            end
         end
         msac_pkg::SVC_DEVDESC_READ: kind = CHK_DEVDESC;
         msac_pkg::SVC_MEM_READ, msac_pkg::SVC_EXT_MEM_READ, msac_pkg::SVC_USER_MEM_READ,
         msac_pkg::SVC_USER_MFR_READ: kind = CHK_READ;
         msac_pkg::SVC_MEM_WRITE, msac_pkg::SVC_EXT_MEM_WRITE, msac_pkg::SVC_USER_MEM_WRITE,
         msac_pkg::SVC_MEM_BIT_WRITE, msac_pkg::SVC_ADC_READ: kind = CHK_WRITE;
         msac_pkg::SVC_RESTART, msac_pkg::SVC_RESTART_MASTER: begin
            rtype = (w.frame_length >= 3'd1) ? w.byte_0[5:0] : 6'd0;
            erase = (rtype == 6'd1 && w.frame_length >= 3'd2) ? w.byte_1 : 8'd0;
            if (rtype != 6'd0) begin
               case (erase)
                  8'h01: pol = PW_STD;
                  8'h02, 8'h05, 8'h06, 8'h07: pol = PW_TOOL;
                  default: pol = PW_NONE;
               endcase
            end
            kind = CHK_SERVICE;
         end
         msac_pkg::SVC_ADDR_WRITE, msac_pkg::SVC_DOMAIN_WRITE, msac_pkg::SVC_DOMAIN_SEL,
         msac_pkg::SVC_ADC_CTRL: begin
            pol = PW_TOOL;
            kind = CHK_SERVICE;
         end
         msac_pkg::SVC_KEY_WRITE, msac_pkg::SVC_AUTH_REQ,
         msac_pkg::SVC_AUTH_RSP: kind = CHK_SERVICE;
         default: ;
      endcase
      rights = right_pair(pol, sm, w.security_level, w.tool_access);
      case (kind)
         CHK_READ:    v = rights[0] ? msac_pkg::VERDICT_ALLOW : msac_pkg::VERDICT_DENY;
         CHK_WRITE:   v = rights[1] ? msac_pkg::VERDICT_ALLOW : msac_pkg::VERDICT_DENY;
         CHK_SERVICE: v = (rights != 2'd0) ? msac_pkg::VERDICT_ALLOW : msac_pkg::VERDICT_DENY;
         CHK_DEVDESC: v = (rights != 2'd0) ? msac_pkg::VERDICT_ALLOW : msac_pkg::VERDICT_VOID;
         default: ;
      endcase
      return v;
   endfunction

   function automatic stim_row_type dir_entry(input int sm, input logic [9:0] svc,
                                              input int len, input int b0, input int b1,
                                              input int b2, input int b3, input int b4,
                                              input int b5, input logic [15:0] iot,
                                              input int sec, input int tool,
                                              input logic [2:0] want);
      stim_row_type r;
      r.sm = 1'(sm);
      r.svc = svc;
      r.w = '0;
      r.w.frame_length = 3'(len);
      r.w.byte_0 = 8'(b0);
      r.w.byte_1 = 8'(b1);
      r.w.byte_2 = 8'(b2);
      r.w.byte_3 = 8'(b3);
      r.w.byte_4 = 8'(b4);
      r.w.byte_5 = 8'(b5);
      r.w.index_object_type = iot;
      r.w.security_level = 2'(sec);
      r.w.tool_access = 1'(tool);
      r.want = want;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < 40) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
      mismatches++;
   endtask

   // ext services carry object type in bytes 1..2 and pid in bytes 4..5
   task automatic make_request(output logic [9:0] svc, output msac_pkg::req_word_type w);
      logic [15:0] obj;
      logic [11:0] pid;
      svc = ($urandom_range(0, 9) == 0) ? 10'($urandom) : SERVICES[$urandom_range(0, 29)];
      w = '0;
      w.frame_length = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd7;
      w.byte_0 = 8'($urandom);
      w.byte_1 = 8'($urandom);
      w.byte_2 = 8'($urandom);
      w.byte_3 = 8'($urandom);
      w.byte_4 = 8'($urandom);
      w.byte_5 = 8'($urandom);
      w.index_object_type = 16'($urandom);
      w.security_level = 2'($urandom_range(0, 3));
      w.tool_access = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) != 0) begin
         obj = OBJECTS[$urandom_range(0, 5)];
         pid = PIDS[$urandom_range(0, 31)];
         w.index_object_type = obj;
         w.byte_2 = pid[7:0];
         if (svc inside {msac_pkg::SVC_EXT_WRITE_CON, msac_pkg::SVC_EXT_WRITE_UCON,
                         msac_pkg::SVC_EXT_FUNC_CMD, msac_pkg::SVC_EXT_READ,
                         msac_pkg::SVC_EXT_FUNC_STATE, msac_pkg::SVC_EXT_DESC_READ}) begin
            w.byte_1 = obj[15:8];
            w.byte_2 = obj[7:0];
            if ($urandom_range(0, 7) != 0) begin
               w.byte_4[3:0] = pid[11:8];
            end
            w.byte_5 = pid[7:0];
         end
         if (svc == msac_pkg::SVC_RESTART || svc == msac_pkg::SVC_RESTART_MASTER) begin
            w.byte_0[5:0] = ($urandom_range(0, 3) == 0) ? 6'($urandom)
                                                        : 6'($urandom_range(0, 1));
            w.byte_1 = ERASE_CODES[$urandom_range(0, 7)];
         end
      end
   endtask

   task automatic put_request(input logic [9:0] svc, input msac_pkg::req_word_type w,
                              input msac_pkg::verdict_type want);
      if (!steady && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= svc;
      req_tdata <= w;
      do @(posedge clock); while (!req_tready);
      pending_verdicts.push_back(want);
   endtask

   // only written with nothing in flight
   task automatic program_secure(input logic mode);
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      secure_now = mode;
   endtask

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 19);
   end

   always @(posedge clock) begin
      msac_pkg::verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("verdict word %h with none pending", rsp_tdata));
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tdata !== {6'b0, want}) begin
               report_mismatch($sformatf("verdict word %h, want verdict %0d",
                                         rsp_tdata, want));
            end
         end
      end
   end

   initial begin
      logic [9:0]             svc;
      msac_pkg::req_word_type w;
      msac_pkg::verdict_type  v;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 1'b0;

      // reset value of secure mode first, then the on half
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_DEVDESC_READ, 0, 0, 0, 0, 0, 0, 0, 16'd0,
                                    0, 0, W_ALLOW));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_PROP_READ, 2, 0, 0, 56, 0, 0, 0, 16'd0,
                                    1, 1, W_DENY));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_PROP_WRITE, 3, 0, 0, 56, 0, 0, 0,
                                    msac_pkg::OBJ_NONE, 2, 0, W_ALLOW));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_EXT_READ, 5, 0, 0, 17, 0, 0, 56, 16'd0,
                                    1, 1, W_DENY));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_EXT_WRITE_UCON, 7, 0, 'h00, 'h11, 0,
                                    'hF0, 'h38, 16'd0, 3, 1, W_PRED));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_DESC_READ, 3, 0, 0, 5, 0, 0, 0,
                                    msac_pkg::OBJ_SEC, 1, 0, W_ALLOW));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_DESC_READ, 4, 0, 0, 0, 0, 0, 0,
                                    msac_pkg::OBJ_SEC, 1, 0, W_ALLOW));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_DESC_READ, 7, 0, 0, 5, 0, 0, 0,
                                    msac_pkg::OBJ_SEC, 1, 0, W_PRED));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_EXT_DESC_READ, 6, 0, 0, 17, 0, 'hF0, 0,
                                    16'd0, 1, 0, W_ALLOW));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_EXT_DESC_READ, 5, 0, 0, 17, 0, 0, 5,
                                    16'd0, 1, 0, W_DENY));
      stim_rows.push_back(dir_entry(0, SVC_UNLISTED_TOP, 0, 0, 0, 0, 0, 0, 0, 16'd0, 0, 0,
                                    W_ALLOW));
      stim_rows.push_back(dir_entry(0, SVC_UNLISTED_LOW, 7, 0, 0, 0, 0, 0, 0, 16'd0, 1, 0,
                                    W_ALLOW));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_PROP_WRITE, 7, 0, 0, 91, 0, 0, 0, 16'd11,
                                    3, 1, W_PRED));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_PROP_READ, 7, 0, 0, 100, 0, 0, 0,
                                    msac_pkg::OBJ_SEC, 2, 1, W_PRED));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_PROP_READ, 7, 0, 0, 2, 0, 0, 0,
                                    msac_pkg::OBJ_SEC, 1, 0, W_PRED));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_RESTART, 0, 'h01, 'h05, 0, 0, 0, 0,
                                    16'd0, 1, 1, W_PRED));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_RESTART, 2, 'hC1, 'h05, 0, 0, 0, 0,
                                    16'd0, 1, 1, W_PRED));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_RESTART_MASTER, 1, 'h01, 'h05, 0, 0, 0,
                                    0, 16'd0, 2, 0, W_PRED));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_MEM_WRITE, 7, 0, 0, 0, 0, 0, 0, 16'd0,
                                    0, 1, W_PRED));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_ADDR_WRITE, 7, 0, 0, 0, 0, 0, 0, 16'd0,
                                    2, 1, W_PRED));
      stim_rows.push_back(dir_entry(0, msac_pkg::SVC_EXT_FUNC_CMD, 7, 'hFF, 'hFF, 'hFF, 'hFF,
                                    'hFF, 'hFF, msac_pkg::OBJ_NONE, 3, 1, W_PRED));
      stim_rows.push_back(dir_entry(1, msac_pkg::SVC_DEVDESC_READ, 7, 0, 0, 0, 0, 0, 0, 16'd0,
                                    0, 0, W_VOID));
      stim_rows.push_back(dir_entry(1, msac_pkg::SVC_MEM_READ, 7, 0, 0, 0, 0, 0, 0, 16'd0,
                                    0, 1, W_DENY));
      stim_rows.push_back(dir_entry(1, msac_pkg::SVC_PROP_READ, 7, 0, 0, 56, 0, 0, 0, 16'd0,
                                    2, 0, W_PRED));
      stim_rows.push_back(dir_entry(1, msac_pkg::SVC_FUNC_STATE_READ, 7, 0, 0, 80, 0, 0, 0,
                                    16'd6, 1, 1, W_PRED));
      stim_rows.push_back(dir_entry(1, msac_pkg::SVC_AUTH_RSP, 7, 0, 0, 0, 0, 0, 0, 16'd0,
                                    3, 0, W_PRED));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].sm != secure_now) begin
            program_secure(stim_rows[i].sm);
         end
         v = stim_rows[i].want[2] ? access_verdict(stim_rows[i].svc, stim_rows[i].w, secure_now)
                                  : msac_pkg::verdict_type'(stim_rows[i].want[1:0]);
         put_request(stim_rows[i].svc, stim_rows[i].w, v);
      end

      // alternate secure mode across the random phases
      for (int ph = 0; ph < 4; ph++) begin
         program_secure(ph[0]);
         for (int n = 0; n < 110; n++) begin
            steady = (ph == 2 && n < 60);
            make_request(svc, w);
            put_request(svc, w, access_verdict(svc, w, secure_now));
         end
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("** management_service_access_check: PASSED **");
      end else begin
         $display("** management_service_access_check: FAILED **");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("** management_service_access_check: FAILED **");
      $finish;
   end

endmodule
